/* rtl/rce_pkg.sv */
package rce_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 18;

    localparam int T_W     = 21;
    localparam int ORDER_W = 2;
    localparam int RADIUS_W = 24;
    localparam int OUT_W   = 32;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXPLICIT = 1'd1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd65536;

    // pi/2 in 32 fraction bits
    localparam logic [33:0] HALFPI_Q32 = 34'd6746518852;
    // 2^56 / (pi/2 * 2^32), used to estimate the quadrant count
    localparam logic [23:0] RECIP_M = 24'(64'h0100_0000_0000_0000 / 64'd6746518852);
    localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         q;
    } rce_lane_t;

    typedef struct packed {
        rce_lane_t          a;
        rce_lane_t          b;
        logic [ORDER_W-1:0] order;
    } rce_word_t;

    typedef struct packed {
        logic signed [32:0] co;
        logic signed [32:0] si;
    } rce_cs_t;

    function automatic logic signed [31:0] rce_atan(input int idx);
        logic signed [31:0] v;
        case (idx)
            0:  v = 32'sh3243F6A8;
            1:  v = 32'sh1DAC6705;
            2:  v = 32'sh0FADBAFC;
            3:  v = 32'sh07F56EA6;
            4:  v = 32'sh03FEAB76;
            5:  v = 32'sh01FFD55B;
            6:  v = 32'sh00FFFAAA;
            7:  v = 32'sh007FFF55;
            8:  v = 32'sh003FFFEA;
            9:  v = 32'sh001FFFFD;
            10: v = 32'sh000FFFFF;
            11: v = 32'sh0007FFFF;
            12: v = 32'sh0003FFFF;
            13: v = 32'sh0001FFFF;
            14: v = 32'sh0000FFFF;
            15: v = 32'sh00007FFF;
            16: v = 32'sh00003FFF;
            17: v = 32'sh00001FFF;
            18: v = 32'sh00000FFF;
            19: v = 32'sh000007FF;
            20: v = 32'sh000003FF;
            21: v = 32'sh000001FF;
            22: v = 32'sh000000FF;
            23: v = 32'sh0000007F;
            24: v = 32'sh0000003F;
            25: v = 32'sh0000001F;
            26: v = 32'sh0000000F;
            27: v = 32'sh00000008;
            28: v = 32'sh00000004;
            29: v = 32'sh00000002;
            30: v = 32'sh00000001;
            default: v = 32'sh00000000;
        endcase
        return v;
    endfunction

    // quadrant unfold of a cordic result into (cos, sin)
    function automatic rce_cs_t rce_quad(input rce_lane_t l);
        rce_cs_t r;
        logic signed [32:0] xe;
        logic signed [32:0] ye;
        xe = 33'(l.x);
        ye = 33'(l.y);
        case (l.q)
            2'd0:
            begin
                r.co = xe;
                r.si = ye;
            end
            2'd1:
            begin
                r.co = -ye;
                r.si = xe;
            end
            2'd2:
            begin
                r.co = -xe;
                r.si = -ye;
            end
            default:
            begin
                r.co = ye;
                r.si = -xe;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/rce_front.sv */
module rce_front #(
    parameter int FRAC_BITS = rce_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rce_pkg::T_W-1:0]      param_t,
    input  logic [rce_pkg::ORDER_W-1:0]  deriv_order,
    output logic                         out_valid,
    input  logic                         out_ready,
    output rce_pkg::rce_word_t           out_word
);
    import rce_pkg::*;

    localparam int ANG_W = (54 - FRAC_BITS > 40) ? 54 - FRAC_BITS : 40;
    localparam int AHI_W = ANG_W - 20;
    localparam int PW    = AHI_W + 24;
    localparam int QW    = PW - 36;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic [ANG_W-1:0]   ang_a_reg, ang_b_reg, ang_a_next, ang_b_next, t7;
    logic [PW-1:0]      prod_a_reg, prod_b_reg, prod_a_next, prod_b_next;
    logic [ORDER_W-1:0] ord1_reg, ord2_reg;
    logic [QW-1:0]      qe_a, qe_b;
    logic [ANG_W-1:0]   rem_a_full, rem_b_full;
    logic [34:0]        rem_a_reg, rem_b_reg;
    logic [1:0]         q_a_reg, q_b_reg;
    logic               ge_a, ge_b;
    logic [34:0]        remc_a, remc_b;
    rce_word_t          word_next, word_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // angles t and 7t/4 in radians with 32 fraction bits
    always_comb
    begin
        ang_a_next  = ANG_W'(param_t) << (32 - FRAC_BITS);
        t7          = (ANG_W'(param_t) << 3) - ANG_W'(param_t);
        ang_b_next  = t7 << (30 - FRAC_BITS);
        prod_a_next = PW'(ang_a_next[ANG_W-1:20]) * PW'(RECIP_M);
        prod_b_next = PW'(ang_b_next[ANG_W-1:20]) * PW'(RECIP_M);
    end

    // quadrant estimate can be one short, fixed in the next stage
    always_comb
    begin
        qe_a       = prod_a_reg[PW-1:36];
        qe_b       = prod_b_reg[PW-1:36];
        rem_a_full = ang_a_reg - ANG_W'(ANG_W'(qe_a) * ANG_W'(HALFPI_Q32));
        rem_b_full = ang_b_reg - ANG_W'(ANG_W'(qe_b) * ANG_W'(HALFPI_Q32));
    end

    always_comb
    begin
        ge_a   = rem_a_reg >= 35'(HALFPI_Q32);
        ge_b   = rem_b_reg >= 35'(HALFPI_Q32);
        remc_a = ge_a ? rem_a_reg - 35'(HALFPI_Q32) : rem_a_reg;
        remc_b = ge_b ? rem_b_reg - 35'(HALFPI_Q32) : rem_b_reg;
        word_next.a.x   = CORDIC_GAIN;
        word_next.a.y   = '0;
        word_next.a.z   = {1'b0, remc_a[32:2]};
        word_next.a.q   = q_a_reg + 2'(ge_a);
        word_next.b.x   = CORDIC_GAIN;
        word_next.b.y   = '0;
        word_next.b.z   = {1'b0, remc_b[32:2]};
        word_next.b.q   = q_b_reg + 2'(ge_b);
        word_next.order = ord2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            ang_a_reg  <= ang_a_next;
            ang_b_reg  <= ang_b_next;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            ord1_reg   <= deriv_order;
        end
        if (rdy2 && v1_reg)
        begin
            rem_a_reg <= rem_a_full[34:0];
            rem_b_reg <= rem_b_full[34:0];
            q_a_reg   <= qe_a[1:0];
            q_b_reg   <= qe_b[1:0];
            ord2_reg  <= ord1_reg;
        end
        if (rdy3 && v2_reg)
            word_reg <= word_next;
    end

    assign out_valid = v3_reg;
    assign out_word  = word_reg;

endmodule

/* rtl/rce_cordic_cell.sv */
module rce_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rce_pkg::rce_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output rce_pkg::rce_word_t out_word
);
    import rce_pkg::*;

    localparam logic signed [31:0] ATAN = rce_atan(SHIFT);

    logic      valid_reg;
    rce_word_t word_reg, word_next;

    function automatic rce_lane_t rotate(input rce_lane_t l);
        rce_lane_t r;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        dx = $signed(l.y) >>> SHIFT;
        dy = $signed(l.x) >>> SHIFT;
        r.q = l.q;
        if (!l.z[31])
        begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - ATAN;
        end
        else
        begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + ATAN;
        end
        return r;
    endfunction

    always_comb
    begin
        word_next.a     = rotate(in_word.a);
        word_next.b     = rotate(in_word.b);
        word_next.order = in_word.order;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* rtl/rce_back.sv */
module rce_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rce_pkg::rce_word_t            in_word,
    input  logic [rce_pkg::RADIUS_W-1:0]  radius,
    input  logic                          explicit_derivatives,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [6*rce_pkg::OUT_W-1:0]   out_data
);
    import rce_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    rce_cs_t cs_t, cs_a;
    logic signed [65:0] m_cact, m_stca, m_sact, m_stsa;
    logic signed [33:0] cact_reg, stca_reg, sact_reg, stsa_reg;
    logic [ORDER_W-1:0] ord1_reg;

    logic signed [37:0] comb_next [6];
    logic signed [37:0] comb_reg  [6];
    logic               vel_en_next, acc_en_next;
    logic               vel_en2_reg, acc_en2_reg, vel_en3_reg, acc_en3_reg;

    logic signed [62:0] scaled_reg [6];
    logic signed [62:0] rnd        [6];
    logic [6*OUT_W-1:0] data_next, data_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // products of cos/sin pairs, rounded half up to 30 fraction bits
    always_comb
    begin
        cs_t   = rce_quad(in_word.a);
        cs_a   = rce_quad(in_word.b);
        m_cact = 66'(cs_a.co * cs_t.co) + 66'sd536870912;
        m_stca = 66'(cs_t.si * cs_a.co) + 66'sd536870912;
        m_sact = 66'(cs_a.si * cs_t.co) + 66'sd536870912;
        m_stsa = 66'(cs_t.si * cs_a.si) + 66'sd536870912;
    end

    // coefficient sums at 34 fraction bits
    always_comb
    begin
        logic signed [37:0] ca;
        logic signed [37:0] sc;
        logic signed [37:0] sa;
        logic signed [37:0] ss;
        ca = 38'(cact_reg);
        sc = 38'(stca_reg);
        sa = 38'(sact_reg);
        ss = 38'(stsa_reg);
        comb_next[0] = 38'sd16 * ca;
        comb_next[1] = 38'sd16 * sc;
        comb_next[2] = -(38'sd28 * sa) - 38'sd16 * sc;
        comb_next[3] = -(38'sd28 * ss) + 38'sd16 * ca;
        comb_next[4] = 38'sd56 * ss - 38'sd65 * ca;
        comb_next[5] = -(38'sd56 * sa) - 38'sd65 * sc;
        vel_en_next  = explicit_derivatives && (ord1_reg != '0);
        acc_en_next  = explicit_derivatives && ord1_reg[1];
    end

    // round to output scale, zero the fields not asked for
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            rnd[i] = (scaled_reg[i] + 63'sd8589934592) >>> 34;
        end
        for (int i = 0; i < 6; i++)
        begin
            logic en;
            en = (i < 2) || (i < 4 ? vel_en3_reg : acc_en3_reg);
            data_next[i*OUT_W +: OUT_W] = en ? rnd[i][OUT_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            cact_reg <= m_cact[63:30];
            stca_reg <= m_stca[63:30];
            sact_reg <= m_sact[63:30];
            stsa_reg <= m_stsa[63:30];
            ord1_reg <= in_word.order;
        end
        if (rdy2 && v1_reg)
        begin
            comb_reg    <= comb_next;
            vel_en2_reg <= vel_en_next;
            acc_en2_reg <= acc_en_next;
        end
        if (rdy3 && v2_reg)
        begin
            for (int i = 0; i < 6; i++)
            begin
                scaled_reg[i] <= 63'(comb_reg[i] * $signed({1'b0, radius}));
            end
            vel_en3_reg <= vel_en2_reg;
            acc_en3_reg <= acc_en2_reg;
        end
        if (rdy4 && v3_reg)
            data_reg <= data_next;
    end

    assign out_valid = v4_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/rose_curve_evaluator.sv */
// throughput: one word per cycle while m_tready is not held low, set by a fully pipelined chain
// with one cordic cell per iteration and one multiplier per product in each stage
// reset: asynchronous active low; clears all stage valids, radius to 1.0, derivatives on
module rose_curve_evaluator #(
    parameter int FRAC_BITS     = rce_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = rce_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // param_t, deriv_order
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [6*rce_pkg::OUT_W-1:0]     m_tdata,   // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
    input  logic                            cfg_we,
    input  logic [rce_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rce_pkg::RADIUS_W-1:0]    cfg_wdata
);
    import rce_pkg::*;

    localparam int N_CELLS = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

    logic [RADIUS_W-1:0] radius_reg;
    logic                explicit_reg;

    logic      cv [N_CELLS+1];
    logic      cr [N_CELLS+1];
    rce_word_t cw [N_CELLS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= RADIUS_RESET;
            explicit_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_RADIUS:   radius_reg   <= cfg_wdata;
                REG_EXPLICIT: explicit_reg <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    rce_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .param_t     (s_tdata[T_W-1:0]),
        .deriv_order (s_tdata[T_W+ORDER_W-1:T_W]),
        .out_valid   (cv[0]),
        .out_ready   (cr[0]),
        .out_word    (cw[0])
    );

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        rce_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_word   (cw[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .out_word  (cw[i+1])
        );
    end

    rce_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (cv[N_CELLS]),
        .in_ready             (cr[N_CELLS]),
        .in_word              (cw[N_CELLS]),
        .radius               (radius_reg),
        .explicit_derivatives (explicit_reg),
        .out_valid            (m_tvalid),
        .out_ready            (m_tready),
        .out_data             (m_tdata)
    );

endmodule
